>>> sv/spiking_neuron_update_macros.svh
// ----------------------------------------------------------------------------
// Spiking neuron update assertion macros
// Concurrent assertion shorthands used by the spiking neuron update top level.
// ----------------------------------------------------------------------------
`ifndef SPIKING_NEURON_UPDATE_MACROS_SVH
`define SPIKING_NEURON_UPDATE_MACROS_SVH

// Check that ante implies cons in the same cycle.
`define SNU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that ante implies cons in the following cycle.
`define SNU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/snu_pkg.sv
// ----------------------------------------------------------------------------
// Spiking neuron update package
// Types, constants and fixed-point widths for the neuron update block.
// ----------------------------------------------------------------------------
package snu_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int NODE_COUNT_DEF = 1024;

    localparam int IDX_W      = 10;
    localparam int Q_W        = 24;
    localparam int RATE_W     = 17;
    localparam int VRST_W     = 24;
    localparam int URST_W     = 22;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int QUEUE_DEPTH = 2;

    localparam longint RATE_RST = 1311;
    localparam longint SENS_RST = 13107;
    localparam longint VRST_RST = -4259840;
    localparam longint URST_RST = 524288;

    // 0.04 in Q0.24
    localparam longint K004    = 671089;
    localparam int     K_W     = 21;
    localparam int     K_SHIFT = 24;

    localparam longint THIRTY    = longint'(30) << FRAC_BITS;
    localparam longint C140      = longint'(140) << FRAC_BITS;
    localparam longint Q_MAX     = (longint'(1) << (Q_W - 1)) - 1;
    localparam longint Q_MIN     = -(longint'(1) << (Q_W - 1));
    localparam longint V_TOP     = (THIRTY > Q_MAX) ? Q_MAX : THIRTY;
    localparam longint DIFF_LIM  = longint'(1) << 40;
    localparam longint RND_F     = longint'(1) << (FRAC_BITS - 1);
    localparam longint RND_K     = longint'(1) << (K_SHIFT - 1);

    localparam int P1_W       = 2 * Q_W;
    localparam int SQ1_W      = 2 * Q_W - FRAC_BITS + 1;
    localparam int P2_W       = SQ1_W + K_W;
    localparam int SQ_W       = P2_W - K_SHIFT + 1;
    localparam int VN_W       = SQ_W + 2;
    localparam int COEF_W     = RATE_W + 1;
    localparam int BVP_W      = VN_W + COEF_W;
    localparam int BV_W       = BVP_W - FRAC_BITS + 1;
    localparam int DIFF_RAW_W = BV_W + 1;
    localparam int DIFF_CAP_W = 42;
    localparam int DIFF_W     = (DIFF_RAW_W < DIFF_CAP_W) ? DIFF_RAW_W : DIFF_CAP_W;
    localparam int DCMP_W     = (DIFF_RAW_W > DIFF_CAP_W) ? DIFF_RAW_W : DIFF_CAP_W;
    localparam int ADP_W      = DIFF_W + COEF_W;
    localparam int AD_W       = ADP_W - FRAC_BITS + 1;
    localparam int UN_W       = AD_W + 1;

    typedef struct packed {
        logic        [IDX_W-1:0] node_index;
        logic signed [Q_W-1:0]   input_current;
    } t_in_item;

    typedef struct packed {
        logic        [IDX_W-1:0] node_echo;
        logic                    spike;
        logic signed [Q_W-1:0]   potential_out;
    } t_out_item;

    typedef struct packed {
        logic        [IDX_W-1:0] node_index;
        logic signed [Q_W-1:0]   input_current;
        logic                    in_range;
    } t_job;

    typedef struct packed {
        logic        [RATE_W-1:0] rate;
        logic        [RATE_W-1:0] sens;
        logic signed [VRST_W-1:0] vrst;
        logic signed [URST_W-1:0] urst;
    } t_cfg;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE = 2'd0,
        CFG_SENS = 2'd1,
        CFG_VRST = 2'd2,
        CFG_URST = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SQUARE,
        ST_SCALE,
        ST_SUM,
        ST_COUPLE,
        ST_DIFF,
        ST_UPDATE
    } t_back_state;

endpackage

>>> sv/snu_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module snu_ram #(
    parameter int WIDTH  = 2 * snu_pkg::Q_W,
    parameter int DEPTH  = snu_pkg::NODE_COUNT_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/snu_front.sv
// ----------------------------------------------------------------------------
// Neuron update front end
// Accept input transfers, tag range, and queue jobs for the back end.
// ----------------------------------------------------------------------------
module snu_front #(
    parameter int NODE_COUNT = snu_pkg::NODE_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  snu_pkg::t_in_item  i_in_data,
    input  logic               i_hold,
    output logic               o_job_valid,
    output snu_pkg::t_job      o_job,
    input  logic               i_job_pop
);

    import snu_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push;
    t_job             job_in;

    assign job_in.node_index    = i_in_data.node_index;
    assign job_in.input_current = i_in_data.input_current;
    assign job_in.in_range      = (32'(i_in_data.node_index) < NODE_COUNT);

    assign o_in_ready  = (r_count != CNT_W'(QUEUE_DEPTH)) && !i_hold;
    assign push        = i_in_valid && o_in_ready;
    assign o_job_valid = (r_count != '0);
    assign o_job       = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_job_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({push, i_job_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= job_in;
        end
    end

endmodule

>>> sv/snu_back.sv
// ----------------------------------------------------------------------------
// Neuron update back end
// Clear the state RAM, then read, update and write back one neuron per in-range job.
// ----------------------------------------------------------------------------
module snu_back #(
    parameter int NODE_COUNT = snu_pkg::NODE_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  snu_pkg::t_job      i_job,
    output logic               o_job_pop,
    input  snu_pkg::t_cfg      i_cfg,
    output logic               o_clearing,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output snu_pkg::t_out_item o_out
);

    import snu_pkg::*;

    localparam int ADDR_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int WORD_W = 2 * Q_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NODE_COUNT - 1);
    localparam logic signed [K_W-1:0] K_CONST = K_W'(K004);

    t_back_state r_state, n_state;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic              r_out_valid;
    t_out_item         r_out, n_out;
    logic              out_load;

    logic [IDX_W-1:0]        r_idx;
    logic signed [Q_W-1:0]   r_cur;
    logic                    r_skip;
    logic                    r_spike;
    logic signed [Q_W-1:0]   r_v, r_u;
    logic signed [SQ1_W-1:0] r_sq1;
    logic signed [SQ_W-1:0]  r_sq;
    logic signed [VN_W-1:0]  r_vn;
    logic signed [BV_W-1:0]  r_bv;
    logic signed [DIFF_W-1:0] r_diff;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;

    logic signed [Q_W-1:0]      rd_v, rd_u;
    logic signed [P1_W-1:0]     p1;
    logic signed [P1_W:0]       p1r;
    logic signed [SQ1_W-1:0]    sq1;
    logic                       spike_hit;
    logic signed [P2_W-1:0]     p2;
    logic signed [P2_W:0]       p2r;
    logic signed [SQ_W-1:0]     sq;
    logic signed [VN_W-1:0]     v_e, vn_sum;
    logic signed [COEF_W-1:0]   coef_a, coef_b;
    logic signed [BVP_W-1:0]    p3;
    logic signed [BVP_W:0]      p3r;
    logic signed [BV_W-1:0]     bv;
    logic signed [DIFF_RAW_W-1:0] diff_raw;
    logic signed [DCMP_W-1:0]   diff_w, diff_cl;
    logic signed [ADP_W-1:0]    p4;
    logic signed [ADP_W:0]      p4r;
    logic signed [AD_W-1:0]     ad;
    logic signed [UN_W-1:0]     un_sum;
    logic signed [Q_W-1:0]      vn_fin, un_fin, vn_new, un_new;

    snu_ram #(
        .WIDTH  (WORD_W),
        .DEPTH  (NODE_COUNT),
        .ADDR_W (ADDR_W)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_v = ram_rdata[WORD_W-1:Q_W];
    assign rd_u = ram_rdata[Q_W-1:0];

    // v*v, rounded to FRAC_BITS
    assign p1        = rd_v * rd_v;
    assign p1r       = (P1_W + 1)'(p1) + (P1_W + 1)'(RND_F);
    assign sq1       = SQ1_W'(p1r >>> FRAC_BITS);
    assign spike_hit = (VN_W'(rd_v) == VN_W'(THIRTY));

    // scale by 0.04
    assign p2  = r_sq1 * K_CONST;
    assign p2r = (P2_W + 1)'(p2) + (P2_W + 1)'(RND_K);
    assign sq  = SQ_W'(p2r >>> K_SHIFT);

    assign v_e    = VN_W'(r_v);
    assign vn_sum = v_e + VN_W'(r_sq) + (v_e <<< 2) + v_e + VN_W'(C140)
                    - VN_W'(r_u) + VN_W'(r_cur);

    assign coef_a = $signed({1'b0, i_cfg.rate});
    assign coef_b = $signed({1'b0, i_cfg.sens});

    assign p3  = coef_b * r_vn;
    assign p3r = (BVP_W + 1)'(p3) + (BVP_W + 1)'(RND_F);
    assign bv  = BV_W'(p3r >>> FRAC_BITS);

    assign diff_raw = DIFF_RAW_W'(r_bv) - DIFF_RAW_W'(r_u);
    assign diff_w   = DCMP_W'(diff_raw);
    assign diff_cl  = (diff_w > DCMP_W'(DIFF_LIM))  ? DCMP_W'(DIFF_LIM)  :
                      (diff_w < DCMP_W'(-DIFF_LIM)) ? DCMP_W'(-DIFF_LIM) : diff_w;

    assign p4     = coef_a * r_diff;
    assign p4r    = (ADP_W + 1)'(p4) + (ADP_W + 1)'(RND_F);
    assign ad     = AD_W'(p4r >>> FRAC_BITS);
    assign un_sum = UN_W'(r_u) + UN_W'(ad);

    assign un_fin = (un_sum > UN_W'(Q_MAX)) ? Q_W'(Q_MAX) :
                    (un_sum < UN_W'(Q_MIN)) ? Q_W'(Q_MIN) : Q_W'(un_sum);
    assign vn_fin = (r_vn > VN_W'(V_TOP)) ? Q_W'(V_TOP) :
                    (r_vn < VN_W'(Q_MIN)) ? Q_W'(Q_MIN) : Q_W'(r_vn);

    assign vn_new = r_spike ? i_cfg.vrst : vn_fin;
    assign un_new = r_spike ? Q_W'(i_cfg.urst) : un_fin;

    assign ram_raddr = ADDR_W'(i_job.node_index);

    always_comb begin
        n_out.node_echo     = r_idx;
        n_out.spike         = r_spike;
        n_out.potential_out = r_skip ? '0 : vn_new;
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        o_job_pop  = 1'b0;
        ram_re     = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = ADDR_W'(r_idx);
        ram_wdata  = {vn_new, un_new};
        out_load   = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    ram_re    = i_job.in_range;
                    n_state   = i_job.in_range ? ST_SQUARE : ST_UPDATE;
                end
            end
            ST_SQUARE: n_state = spike_hit ? ST_UPDATE : ST_SCALE;
            ST_SCALE:  n_state = ST_SUM;
            ST_SUM:    n_state = ST_COUPLE;
            ST_COUPLE: n_state = ST_DIFF;
            ST_DIFF:   n_state = ST_UPDATE;
            ST_UPDATE: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    ram_we   = !r_skip;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= out_load || (r_out_valid && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_idx   <= i_job.node_index;
                r_cur   <= i_job.input_current;
                r_skip  <= !i_job.in_range;
                r_spike <= 1'b0;
            end
            ST_SQUARE: begin
                r_v     <= rd_v;
                r_u     <= rd_u;
                r_sq1   <= sq1;
                r_spike <= spike_hit;
            end
            ST_SCALE:  r_sq   <= sq;
            ST_SUM:    r_vn   <= vn_sum;
            ST_COUPLE: r_bv   <= bv;
            ST_DIFF:   r_diff <= DIFF_W'(diff_cl);
            default: ;
        endcase
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_clearing  = (r_state == ST_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> sv/spiking_neuron_update.sv
// ----------------------------------------------------------------------------
// Spiking neuron update: per-item cost is set by the back end sequencer.
// An update walks IDLE, SQUARE, SCALE, SUM, COUPLE, DIFF and UPDATE; a firing
// neuron goes from SQUARE to UPDATE, an index beyond range from IDLE to UPDATE.
// Reset clears the state RAM with input held off.
// ----------------------------------------------------------------------------
`include "spiking_neuron_update_macros.svh"

module spiking_neuron_update #(
    parameter int NODE_COUNT = snu_pkg::NODE_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  snu_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output snu_pkg::t_out_item              o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [snu_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [snu_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import snu_pkg::*;

    t_cfg  r_cfg;
    logic  clearing;
    logic  job_valid;
    logic  job_pop;
    t_job  job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate <= RATE_W'(RATE_RST);
            r_cfg.sens <= RATE_W'(SENS_RST);
            r_cfg.vrst <= VRST_W'(VRST_RST);
            r_cfg.urst <= URST_W'(URST_RST);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_RATE: r_cfg.rate <= i_cfg_data[RATE_W-1:0];
                CFG_SENS: r_cfg.sens <= i_cfg_data[RATE_W-1:0];
                CFG_VRST: r_cfg.vrst <= i_cfg_data[VRST_W-1:0];
                CFG_URST: r_cfg.urst <= i_cfg_data[URST_W-1:0];
                default: ;
            endcase
        end
    end

    snu_front #(
        .NODE_COUNT (NODE_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_hold      (clearing),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    snu_back #(
        .NODE_COUNT (NODE_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .i_cfg       (r_cfg),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out_data)
    );

    `SNU_ASSERT_IMP(a_no_transfer_in_clear, i_clk, i_rst_n, clearing, !o_in_ready, "input taken during RAM clear")
    `SNU_ASSERT_NXT(a_clear_only_once, i_clk, i_rst_n, !clearing, !clearing, "RAM clear restarted")
    `SNU_ASSERT_IMP(a_range_result, i_clk, i_rst_n, o_out_valid && (32'(o_out_data.node_echo) >= NODE_COUNT), !o_out_data.spike && (o_out_data.potential_out == '0), "bad result for index beyond range")
    `SNU_ASSERT_IMP(a_potential_cap, i_clk, i_rst_n, o_out_valid && !o_out_data.spike, o_out_data.potential_out <= Q_W'(V_TOP), "potential above clamp")

endmodule
